// ----- design/battery_voltage_gauge_unit_defines.svh -----
// Assertion macros shared by the battery voltage gauge RTL.
`ifndef BATTERY_VOLTAGE_GAUGE_UNIT_DEFINES_SVH
`define BATTERY_VOLTAGE_GAUGE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BVG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define BVG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BVG_ASSERT_IMP(name, ante, cons)
`define BVG_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ----- design/bvg_pkg.sv -----
// Package with widths, constants, types and helpers of the battery voltage gauge.
package bvg_pkg;

  localparam int MvW       = 12;
  localparam int PctW      = 7;
  localparam int StW       = 2;
  localparam int CapNumW   = MvW + PctW;
  localparam int ApbDataW  = 32;
  localparam int PaddrW    = 3;
  localparam int RegIdxLsb = 2;

  localparam logic [MvW-1:0] ChgLoMv    = 12'd3500;
  localparam logic [MvW-1:0] ChgHiMv    = 12'd4020;
  localparam logic [MvW-1:0] ChgDropMid = 12'd200;
  localparam logic [MvW-1:0] ChgDropHi  = 12'd100;
  localparam logic [MvW-1:0] DisRiseMv  = 12'd100;
  localparam logic [MvW-1:0] TopMv      = 12'd4044;
  localparam logic [MvW-1:0] FullMvRst  = 12'd4050;
  localparam logic [MvW-1:0] EmptyMvRst = 12'd3350;

  localparam logic [PctW-1:0] PctFull = 7'd100;
  localparam logic [PctW-1:0] PctTop  = 7'd99;
  localparam logic [PctW-1:0] PctLow  = 7'd1;

  typedef enum logic [StW-1:0] {
    CS_DISCHG = 2'd0,
    CS_CHG    = 2'd1,
    CS_FULL   = 2'd2
  } chg_state_e;

  typedef enum logic {
    REG_FULL_MV  = 1'b0,
    REG_EMPTY_MV = 1'b1
  } reg_idx_e;

  // Numerator of the capacity division: the voltage clamped into the
  // empty..full window, offset by empty and scaled to percent.
  function automatic logic [CapNumW-1:0] cap_num(input logic [MvW-1:0] v,
                                                 input logic [MvW-1:0] full,
                                                 input logic [MvW-1:0] empty);
    logic [MvW-1:0] vc;
    vc = v;
    if (vc >= full) vc = full;
    if (vc <= empty) vc = empty;
    return CapNumW'(vc - empty) * CapNumW'(PctFull);
  endfunction

endpackage

// ----- design/bvg_if.sv -----
// Handshake channel interfaces for measurement items and report items.
interface bvg_meas_if;
  import bvg_pkg::*;

  logic           valid;
  logic           ready;
  logic [MvW-1:0] raw_mv;
  logic           adc_error;
  logic           charger_present;
  logic           charge_full;

  modport source (output valid, output raw_mv, output adc_error,
                  output charger_present, output charge_full, input ready);
  modport sink   (input valid, input raw_mv, input adc_error,
                  input charger_present, input charge_full, output ready);
endinterface

interface bvg_rpt_if;
  import bvg_pkg::*;

  logic            valid;
  logic            ready;
  logic [MvW-1:0]  voltage_mv;
  logic [PctW-1:0] capacity_pct;
  logic [StW-1:0]  charge_state;

  modport source (output valid, output voltage_mv, output capacity_pct,
                  output charge_state, input ready);
  modport sink   (input valid, input voltage_mv, input capacity_pct,
                  input charge_state, output ready);
endinterface

// ----- design/bvg_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module bvg_ram #(
  parameter int Width = 12,
  parameter int Depth = 15,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/battery_voltage_gauge_unit.sv -----
// Top level of the battery voltage gauge: sample ring, averaging, blend and capacity.
//
//   Channel   Direction  Handshake        Carries
//   meas_i    in         valid / ready    raw_mv, adc_error, charger_present, charge_full
//   rpt_o     out        valid / ready    voltage_mv, capacity_pct, charge_state
//   APB       in         psel / penable   full_mv (0x0), empty_mv (0x4)
//
// An accepted item is walked over the sample ring (one memory read per cycle) and then
// takes up to four passes of the shared radix-4 divider, each a load step followed by its
// iterations; at most the capacity pass is made when the ring average is not used (count zero).
// Reset clears the sample ring at once through per-entry valid bits; no clearing pass.
// One item is in work at a time; a finished report waits in the output register while
// the next item is accepted and processed, and only its final write-back stalls on rpt_o.
module battery_voltage_gauge_unit #(
  parameter int RING_DEPTH   = 15,
  parameter int WARMUP_COUNT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bvg_meas_if.sink                       meas_i,
  bvg_rpt_if.source                      rpt_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bvg_pkg::PaddrW-1:0]     paddr,
  input  logic [bvg_pkg::ApbDataW-1:0]   pwdata,
  output logic [bvg_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);
  import bvg_pkg::*;

  `include "battery_voltage_gauge_unit_defines.svh"

  // Ring addressing and accumulator widths follow from the ring depth.
  localparam int AW       = $clog2(RING_DEPTH);
  localparam int CntW     = $clog2(RING_DEPTH + 1);
  localparam int WarmW    = $clog2(WARMUP_COUNT + 1);
  localparam int CmpW     = (CntW > WarmW) ? CntW : WarmW;
  localparam int SumW     = MvW + CntW;
  localparam int DivW     = (SumW > CapNumW) ? SumW : CapNumW;
  localparam int DivPadW  = DivW + (DivW % 2);
  localparam int DvsW     = (MvW > CntW) ? MvW : CntW;
  localparam int DivSteps = DivPadW / 2;
  localparam int StepW    = $clog2(DivSteps);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_PREP = 8'b0000_0100,
    ST_CAP  = 8'b0000_1000,
    ST_AVG  = 8'b0001_0000,
    ST_BLD  = 8'b0010_0000,
    ST_BCAP = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [MvW-1:0] full_q, empty_q;
  logic           cfg_we;
  logic           span_zero;

  // Latched measurement item.
  logic [MvW-1:0] raw_q;
  logic           err_q, chg_q, cfull_q;

  // Ring walk.
  logic [CntW-1:0]       scan_idx_q;
  logic                  scan_rd;
  logic [AW-1:0]         ram_raddr;
  logic [MvW-1:0]        ram_rdata;
  logic                  rd_pend_q, rd_vld_q;
  logic [SumW-1:0]       sum_q;
  logic [CntW-1:0]       cnt_q;
  logic [RING_DEPTH-1:0] valid_q;
  logic [AW-1:0]         slot_q;
  logic                  warm_q;
  logic [CmpW-1:0]       cnt_ext;

  // Per-item working values.
  logic [MvW:0]    corr_b;
  logic [MvW-1:0]  batt_d, batt_q;
  logic            low_d, low_q;
  logic            cnt_zero_q;
  logic [PctW-1:0] cap_q, bcap_q;
  logic [MvW-1:0]  avg_q, blend_q;
  logic [SumW-1:0] blend_num;

  // Shared divider.
  logic               div_run_q;
  logic [DivPadW-1:0] div_quo_q, div_quo_nx, div_num;
  logic [DvsW-1:0]    div_rem_q, div_rem_nx, div_dvs_q, div_den, div_r;
  logic [DvsW:0]      div_trial;
  logic [StepW-1:0]   div_step_q;
  logic               div_state, div_skip, div_launch, div_done;

  // Reported values double as the output register.
  logic [MvW-1:0]  rep_v_q, rep_v_d;
  logic [PctW-1:0] rep_cap_q, rep_cap_d;
  chg_state_e      rep_st_q, rep_st_d;
  logic [MvW-1:0]  ring_wdata;
  logic            out_valid_q;
  logic            fin_go;
  logic            in_acc;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are free.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[RegIdxLsb]))
      REG_FULL_MV:  prdata = ApbDataW'(full_q);
      REG_EMPTY_MV: prdata = ApbDataW'(empty_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q  <= FullMvRst;
      empty_q <= EmptyMvRst;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[RegIdxLsb]))
        REG_FULL_MV:  full_q  <= pwdata[MvW-1:0];
        REG_EMPTY_MV: empty_q <= pwdata[MvW-1:0];
        default: ;
      endcase
    end
  end

  // With no span between empty and full, both computed capacities read as zero and the
  // capacity divisions are skipped.
  assign span_zero = (full_q <= empty_q);

  // ---------------------------------------------------------------------------
  // Handshakes.
  // ---------------------------------------------------------------------------
  assign meas_i.ready       = (state_q == ST_IDLE);
  assign in_acc             = meas_i.valid && meas_i.ready;
  assign fin_go             = (state_q == ST_FIN) && (!out_valid_q || rpt_o.ready);
  assign rpt_o.valid        = out_valid_q;
  assign rpt_o.voltage_mv   = rep_v_q;
  assign rpt_o.capacity_pct = rep_cap_q;
  assign rpt_o.charge_state = rep_st_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q   <= meas_i.raw_mv;
      err_q   <= meas_i.adc_error;
      chg_q   <= meas_i.charger_present;
      cfull_q <= meas_i.charge_full;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (scan_idx_q == CntW'(RING_DEPTH)) state_d = ST_PREP;
      ST_PREP: state_d = ST_CAP;
      ST_CAP:  if (div_done || div_skip) state_d = cnt_zero_q ? ST_FIN : ST_AVG;
      ST_AVG:  if (div_done) state_d = ST_BLD;
      ST_BLD:  if (div_done) state_d = ST_BCAP;
      ST_BCAP: if (div_done || div_skip) state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring walk: one memory read per cycle, accumulated in the cycle after. Entries
  // whose valid bit is clear, or that hold zero, are not counted.
  // ---------------------------------------------------------------------------
  assign scan_rd   = (state_q == ST_SCAN) && (scan_idx_q != CntW'(RING_DEPTH));
  assign ram_raddr = scan_rd ? scan_idx_q[AW-1:0] : '0;

  bvg_ram #(
    .Width (MvW),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (fin_go),
    .waddr_i (slot_q),
    .wdata_i (ring_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_pend_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_pend_q <= scan_rd;
      rd_vld_q  <= valid_q[ram_raddr];
      if (in_acc) begin
        scan_idx_q <= '0;
      end else if (scan_rd) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if ((state_q == ST_SCAN) && rd_pend_q && rd_vld_q && (ram_rdata != '0)) begin
      sum_q <= sum_q + SumW'(ram_rdata);
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Valid bits, write slot and warm-up flag. The ring is emptied once, the
  // first time the walk finds exactly the warm-up count of nonzero entries.
  assign cnt_ext = CmpW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      slot_q  <= '0;
      warm_q  <= 1'b0;
    end else begin
      if ((state_q == ST_PREP) && !warm_q && (cnt_ext == CmpW'(WARMUP_COUNT))) begin
        valid_q <= '0;
        warm_q  <= 1'b1;
      end else if (fin_go) begin
        valid_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == AW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Charger correction and clamp of the raw reading.
  // ---------------------------------------------------------------------------
  always_comb begin
    corr_b = {1'b0, raw_q};
    low_d  = 1'b0;
    batt_d = '0;
    if (chg_q) begin
      if ((raw_q > ChgLoMv) && (raw_q <= ChgHiMv)) begin
        corr_b = {1'b0, raw_q - ChgDropMid};
      end else if (raw_q > ChgHiMv) begin
        corr_b = {1'b0, raw_q - ChgDropHi};
      end
    end else begin
      corr_b = {1'b0, raw_q} + {1'b0, DisRiseMv};
    end
    if (chg_q && (corr_b <= {1'b0, empty_q})) begin
      low_d  = 1'b1;
      batt_d = empty_q;
    end else if (corr_b >= {1'b0, full_q}) begin
      batt_d = full_q;
    end else if (corr_b <= {1'b0, empty_q}) begin
      batt_d = empty_q;
    end else begin
      batt_d = corr_b[MvW-1:0];
    end
    // A failed conversion reports zero volts with no correction at all.
    if (err_q) begin
      batt_d = '0;
      low_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      batt_q     <= batt_d;
      low_q      <= low_d;
      // Before warm-up completes, a count up to the warm-up figure means no average.
      cnt_zero_q <= (cnt_q == '0) || (!warm_q && (cnt_ext <= CmpW'(WARMUP_COUNT)));
    end
  end

  // ---------------------------------------------------------------------------
  // Shared radix-4 restoring divider. Each division is a load step followed by
  // DivSteps iterations; the quotient is caught on the last iteration.
  // ---------------------------------------------------------------------------
  assign blend_num = SumW'(batt_q) + SumW'(avg_q) * SumW'(RING_DEPTH - 1);

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (state_q)
      ST_CAP: begin
        div_num = DivPadW'(cap_num(batt_q, full_q, empty_q));
        div_den = DvsW'(full_q - empty_q);
      end
      ST_AVG: begin
        div_num = DivPadW'(sum_q);
        div_den = DvsW'(cnt_q);
      end
      ST_BLD: begin
        div_num = DivPadW'(blend_num);
        div_den = DvsW'(RING_DEPTH);
      end
      ST_BCAP: begin
        div_num = DivPadW'(cap_num(blend_q, full_q, empty_q));
        div_den = DvsW'(full_q - empty_q);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign div_state  = (state_q == ST_CAP) || (state_q == ST_AVG) ||
                      (state_q == ST_BLD) || (state_q == ST_BCAP);
  assign div_skip   = span_zero && ((state_q == ST_CAP) || (state_q == ST_BCAP));
  assign div_launch = div_state && !div_run_q && !div_skip;
  assign div_done   = div_run_q && (div_step_q == StepW'(DivSteps - 1));

  always_comb begin
    div_r      = div_rem_q;
    div_quo_nx = div_quo_q;
    div_trial  = '0;
    for (int k = 0; k < 2; k++) begin
      div_trial  = {div_r, div_quo_nx[DivPadW-1]};
      div_quo_nx = {div_quo_nx[DivPadW-2:0], 1'b0};
      if (div_trial >= {1'b0, div_dvs_q}) begin
        div_trial     = div_trial - {1'b0, div_dvs_q};
        div_quo_nx[0] = 1'b1;
      end
      div_r = div_trial[DvsW-1:0];
    end
    div_rem_nx = div_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q <= 1'b0;
    end else if (div_launch) begin
      div_run_q <= 1'b1;
    end else if (div_done) begin
      div_run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_launch) begin
      div_quo_q  <= div_num;
      div_rem_q  <= '0;
      div_dvs_q  <= div_den;
      div_step_q <= '0;
    end else if (div_run_q) begin
      div_quo_q  <= div_quo_nx;
      div_rem_q  <= div_rem_nx;
      div_step_q <= div_step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CAP) begin
      if (div_skip) begin
        cap_q <= '0;
      end else if (div_done) begin
        cap_q <= div_quo_nx[PctW-1:0];
      end
    end
    if ((state_q == ST_AVG) && div_done) begin
      avg_q <= div_quo_nx[MvW-1:0];
    end
    if ((state_q == ST_BLD) && div_done) begin
      blend_q <= div_quo_nx[MvW-1:0];
    end
    if (state_q == ST_BCAP) begin
      if (div_skip) begin
        bcap_q <= '0;
      end else if (div_done) begin
        bcap_q <= div_quo_nx[PctW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final decision: reported voltage, capacity and state, and the ring entry.
  // Blend values are only used when the average counted.
  // ---------------------------------------------------------------------------
  always_comb begin
    rep_v_d    = rep_v_q;
    rep_cap_d  = rep_cap_q;
    rep_st_d   = rep_st_q;
    ring_wdata = batt_q;
    if (!chg_q) begin
      if (cnt_zero_q) begin
        rep_v_d   = batt_q;
        rep_cap_d = cap_q;
      end else begin
        // With an average counted, discharging never lets the reported capacity climb.
        if (bcap_q <= rep_cap_q) begin
          rep_v_d   = blend_q;
          rep_cap_d = bcap_q;
        end
        if (blend_q > full_q) rep_v_d = full_q;
      end
      rep_st_d = CS_DISCHG;
    end else if (low_q) begin
      rep_cap_d  = PctLow;
      rep_v_d    = empty_q;
      rep_st_d   = CS_CHG;
      ring_wdata = ChgLoMv;
    end else if (cfull_q) begin
      rep_cap_d  = PctFull;
      rep_v_d    = full_q;
      rep_st_d   = CS_FULL;
      ring_wdata = full_q;
    end else if (cap_q == PctFull) begin
      // Charging at the top but not yet complete holds just below full.
      rep_cap_d  = PctTop;
      rep_v_d    = TopMv;
      rep_st_d   = CS_CHG;
      ring_wdata = TopMv;
    end else if (cnt_zero_q) begin
      rep_v_d   = batt_q;
      rep_cap_d = cap_q;
      rep_st_d  = CS_CHG;
    end else begin
      // Charging is confirmed only while capacity does not fall.
      rep_st_d  = (bcap_q >= rep_cap_q) ? CS_CHG : CS_DISCHG;
      rep_v_d   = (blend_q > full_q) ? full_q : blend_q;
      rep_cap_d = bcap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_v_q     <= FullMvRst;
      rep_cap_q   <= PctFull;
      rep_st_q    <= CS_DISCHG;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        rep_v_q     <= rep_v_d;
        rep_cap_q   <= rep_cap_d;
        rep_st_q    <= rep_st_d;
        out_valid_q <= 1'b1;
      end else if (rpt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `BVG_ASSERT_NXT(a_accept_starts_walk, meas_i.valid && meas_i.ready, state_q == ST_SCAN)
  `BVG_ASSERT_IMP(a_walk_in_range, state_q == ST_SCAN, scan_idx_q <= CntW'(RING_DEPTH))
  `BVG_ASSERT_IMP(a_divisor_nonzero, div_run_q, div_dvs_q != '0)
  `BVG_ASSERT_IMP(a_capacity_in_range, out_valid_q, rep_cap_q <= PctFull)

endmodule
